// ===== hw/rtl/srlp_pkg.sv =====
`default_nettype none

package srlp_pkg;

   localparam int STATE_W   = 40;
   localparam int DIFF_W    = STATE_W + 1;
   localparam int SAMPLE_W  = 16;
   localparam int COEF_W    = 16;
   localparam int COEF_FRAC = 15;
   localparam int MUL_SPLIT = 24;

   localparam int DEFAULT_SAMPLE_SHIFT  = 3;
   localparam int DEFAULT_FRACTION_BITS = 16;

endpackage

`default_nettype wire

// ===== hw/rtl/stereo_resonant_lowpass_unit.sv =====
`default_nettype none

// Resonant two-pole lowpass for interleaved stereo audio, right channel first
// in every buffer. Each request carries one sample with its own cutoff and
// resonance (unsigned Q1.15) and gives exactly one filtered sample back, in
// order. A request is captured in an input register and filtered on its way
// to the output register; the per-channel position and momentum are updated
// as the result is registered, so a request can be accepted on every clock
// while the output is not stalled. Each coefficient product is formed from
// two partial products of the 41-bit distance, and the channel state wraps
// at 40 bits as two's complement.
module stereo_resonant_lowpass_unit
   import srlp_pkg::*;
#(
   parameter int SAMPLE_SHIFT  = DEFAULT_SAMPLE_SHIFT,
   parameter int FRACTION_BITS = DEFAULT_FRACTION_BITS
) (
   input  logic                       clock,
   input  logic                       reset,

   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic signed [SAMPLE_W-1:0] req_sample_in,
   input  logic        [COEF_W-1:0]   req_cutoff,
   input  logic        [COEF_W-1:0]   req_resonance,
   input  logic                       req_end_of_buffer,

   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [SAMPLE_W-1:0] rsp_sample_out
);

   localparam int Y_W      = STATE_W - FRACTION_BITS;
   localparam int PROD_W   = DIFF_W + COEF_W + 1;
   localparam int HI_W     = DIFF_W - MUL_SPLIT;

   localparam logic signed [Y_W-1:0] SAT_HI = Y_W'((1 << (SAMPLE_W - 1 - SAMPLE_SHIFT)) - 1);
   localparam logic signed [Y_W-1:0] SAT_LO = ~SAT_HI;

   // coefficient times distance, floored by 2^15, wrapped to the state width
   function automatic logic signed [STATE_W-1:0] scale_coef(
      input logic signed [DIFF_W-1:0] diff,
      input logic        [COEF_W-1:0] coef
   );
      logic        [MUL_SPLIT+COEF_W-1:0] p_lo;
      logic signed [HI_W+COEF_W:0]        p_hi;
      logic signed [PROD_W-1:0]           prod;
      p_lo = diff[MUL_SPLIT-1:0] * coef;
      p_hi = $signed(diff[DIFF_W-1:MUL_SPLIT]) * $signed({1'b0, coef});
      prod = (PROD_W'(p_hi) <<< MUL_SPLIT) + $signed(PROD_W'(p_lo));
      return prod[COEF_FRAC+STATE_W-1:COEF_FRAC];
   endfunction

   logic                       s1_valid_ff, s1_valid_in;
   logic signed [SAMPLE_W-1:0] s1_sample_ff;
   logic        [COEF_W-1:0]   s1_cutoff_ff;
   logic        [COEF_W-1:0]   s1_resonance_ff;
   logic                       s1_eob_ff;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0] rsp_sample_ff, rsp_sample_in;

   logic                       chan_left_ff, chan_left_in;
   logic signed [STATE_W-1:0]  r_pos_ff, r_pos_in;
   logic signed [STATE_W-1:0]  r_mom_ff, r_mom_in;
   logic signed [STATE_W-1:0]  l_pos_ff, l_pos_in;
   logic signed [STATE_W-1:0]  l_mom_ff, l_mom_in;

   logic                       out_free;
   logic                       advance;
   logic                       take;

   logic signed [SAMPLE_W-1:0] sample_sh;
   logic signed [DIFF_W-1:0]   target;
   logic signed [DIFF_W-1:0]   delta;
   logic signed [STATE_W-1:0]  pos_cur, mom_cur;
   logic signed [STATE_W-1:0]  pos_new, mom_new;
   logic signed [Y_W-1:0]      y_floor, y_trunc, y_sat;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;
   assign take      = req_valid && !req_stall;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_ff;

   // filter datapath
   always_comb begin
      pos_cur   = chan_left_ff ? l_pos_ff : r_pos_ff;
      mom_cur   = chan_left_ff ? l_mom_ff : r_mom_ff;
      sample_sh = s1_sample_ff >>> SAMPLE_SHIFT;
      target    = DIFF_W'(sample_sh) <<< FRACTION_BITS;
      delta     = target - DIFF_W'(pos_cur);
      mom_new   = mom_cur + scale_coef(delta, s1_cutoff_ff);
      pos_new   = pos_cur + mom_new + scale_coef(delta, s1_resonance_ff);

      // truncate toward zero
      y_floor = pos_new[STATE_W-1:FRACTION_BITS];
      y_trunc = y_floor + $signed(Y_W'(pos_new[STATE_W-1] && (|pos_new[FRACTION_BITS-1:0])));

      if (y_trunc > SAT_HI) begin
         y_sat = SAT_HI;
      end else if (y_trunc < SAT_LO) begin
         y_sat = SAT_LO;
      end else begin
         y_sat = y_trunc;
      end
      rsp_sample_in = SAMPLE_W'(y_sat <<< SAMPLE_SHIFT);
   end

   // control and state next values
   always_comb begin
      s1_valid_in  = take ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
      rsp_valid_in = advance ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);
      chan_left_in = chan_left_ff;
      r_pos_in     = r_pos_ff;
      r_mom_in     = r_mom_ff;
      l_pos_in     = l_pos_ff;
      l_mom_in     = l_mom_ff;
      if (advance) begin
         chan_left_in = s1_eob_ff ? 1'b0 : !chan_left_ff;
         if (chan_left_ff) begin
            l_pos_in = pos_new;
            l_mom_in = mom_new;
         end else begin
            r_pos_in = pos_new;
            r_mom_in = mom_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         chan_left_ff <= 1'b0;
         r_pos_ff     <= '0;
         r_mom_ff     <= '0;
         l_pos_ff     <= '0;
         l_mom_ff     <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         chan_left_ff <= chan_left_in;
         r_pos_ff     <= r_pos_in;
         r_mom_ff     <= r_mom_in;
         l_pos_ff     <= l_pos_in;
         l_mom_ff     <= l_mom_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         s1_sample_ff    <= req_sample_in;
         s1_cutoff_ff    <= req_cutoff;
         s1_resonance_ff <= req_resonance;
         s1_eob_ff       <= req_end_of_buffer;
      end
      if (advance) begin
         rsp_sample_ff <= rsp_sample_in;
      end
   end

   // checks
   a_reset_empty : assert property (@(posedge clock)
      reset |=> (!s1_valid_ff && !rsp_valid_ff && !chan_left_ff))
      else $error("pipeline not empty after reset");

   a_advance_out : assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("filtered request did not reach the output register");

   a_eob_right : assert property (@(posedge clock) disable iff (reset)
      (advance && s1_eob_ff) |=> !chan_left_ff)
      else $error("channel order not restarted at end of buffer");

   a_state_hold : assert property (@(posedge clock) disable iff (reset)
      !advance |=> ($stable(r_pos_ff) && $stable(l_pos_ff) && $stable(chan_left_ff)))
      else $error("channel state changed without a request");

endmodule

`default_nettype wire
